FILE: src/sha1_message_digest_defines.svh
// assertion macros for the sha-1 digest block
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SHA1MD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// checked during reset too
`define SHA1MD_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: src/sha1md_pkg.sv
package sha1md_pkg;

   // what a queued item asks of the back end
   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_BYTE_END,
      KIND_END
   } item_kind_type;

   typedef struct packed {
      logic [7:0]    data;
      item_kind_type kind;
   } q_entry_type;

   typedef enum logic [2:0] {
      ST_ABSORB,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } back_state_type;

   localparam int unsigned HASH_WORDS = 5;
   localparam int unsigned ROUNDS     = 80;

   localparam logic [HASH_WORDS-1:0][31:0] H_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

   function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      priority if (rnd < 7'd20) f = d ^ (b & (c ^ d));
      else if (rnd < 7'd40) f = b ^ c ^ d;
      else if (rnd < 7'd60) f = (b & c) | (d & (b | c));
      else f = b ^ c ^ d;
      return f;
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] rnd);
      logic [31:0] k;
      priority if (rnd < 7'd20) k = 32'h5A827999;
      else if (rnd < 7'd40) k = 32'h6ED9EBA1;
      else if (rnd < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
   endfunction

endpackage

FILE: src/sha1md_front.sv
module sha1md_front (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_is_last,
   input  logic                    req_no_data,
   input  logic                    q_full,
   output logic                    q_push,
   output sha1md_pkg::q_entry_type q_entry
);
   import sha1md_pkg::*;

   logic no_effect;

   // an empty item that does not end the message changes nothing
   assign no_effect = req_no_data & ~req_is_last;
   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full & ~no_effect;

   always_comb begin
      q_entry.data = req_data_byte;
      priority if (req_no_data) q_entry.kind = KIND_END;
      else if (req_is_last) q_entry.kind = KIND_BYTE_END;
      else q_entry.kind = KIND_BYTE;
   end

endmodule

FILE: src/sha1md_fifo.sv
module sha1md_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sha1md_pkg::q_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output sha1md_pkg::q_entry_type pop_entry
);
   import sha1md_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   q_entry_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/sha1md_back.sv
module sha1md_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  sha1md_pkg::q_entry_type q_entry,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [31:0]             rsp_digest_word,
   output logic [2:0]              rsp_word_index,
   output logic                    rsp_digest_end
);
   import sha1md_pkg::*;

   back_state_type                 state_ff, state_in;
   logic [5:0]                     pos_ff, pos_in;
   logic [63:0]                    count_ff, count_in;
   logic [HASH_WORDS-1:0][31:0]    chain_ff, chain_in;
   logic [HASH_WORDS-1:0][31:0]    work_ff, work_in;
   logic [511:0]                   blk_ff, blk_in;
   logic [6:0]                     round_ff, round_in;
   logic                           pad_ff, pad_in;
   logic                           mark_ff, mark_in;
   logic                           lenph_ff, lenph_in;
   logic                           fin_ff, fin_in;
   logic [2:0]                     emit_ff, emit_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [31:0]                    rsp_word_ff, rsp_word_in;
   logic [2:0]                     rsp_index_ff, rsp_index_in;
   logic                           rsp_end_ff, rsp_end_in;

   logic                           byte_wr;
   logic [7:0]                     byte_val;
   logic                           last_lane;
   logic                           len_sel;
   logic [7:0][7:0]                len_bytes;
   logic [31:0]                    w0, w2, w8, w13, w_mix;
   logic [31:0]                    ra, rb, rc, rd, re, t_sum;
   logic                           out_load;

   assign last_lane = (pos_ff == 6'd63);
   assign len_bytes = count_ff;
   // length bytes run from lane 56 of the block that closes the message
   assign len_sel   = mark_ff & (lenph_ff | (pos_ff == 6'd56));

   // block held as a window of 16 schedule words, word 0 at the top
   assign w0    = blk_ff[511:480];
   assign w2    = blk_ff[447:416];
   assign w8    = blk_ff[255:224];
   assign w13   = blk_ff[95:64];
   assign w_mix = w13 ^ w8 ^ w2 ^ w0;

   assign ra    = work_ff[0];
   assign rb    = work_ff[1];
   assign rc    = work_ff[2];
   assign rd    = work_ff[3];
   assign re    = work_ff[4];
   assign t_sum = {ra[26:0], ra[31:27]} + round_f(round_ff, rb, rc, rd) + re
                  + round_k(round_ff) + w0;

   assign out_load = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      blk_in       = blk_ff;
      round_in     = round_ff;
      pad_in       = pad_ff;
      mark_in      = mark_ff;
      lenph_in     = lenph_ff;
      fin_in       = fin_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_end_in   = rsp_end_ff;
      q_pop        = 1'b0;
      byte_wr      = 1'b0;
      byte_val     = q_entry.data;

      unique case (state_ff)
         ST_ABSORB: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.kind != KIND_BYTE) begin
                  pad_in   = 1'b1;
                  state_in = ST_PAD;
               end
               if (q_entry.kind != KIND_END) begin
                  byte_wr  = 1'b1;
                  count_in = count_ff + 64'd8;
               end
            end
         end
         ST_PAD: begin
            byte_wr = 1'b1;
            mark_in = 1'b1;
            if (!mark_ff) begin
               byte_val = PAD_MARK;
            end else if (len_sel) begin
               byte_val = len_bytes[3'd7 - pos_ff[2:0]];
               lenph_in = 1'b1;
               fin_in   = last_lane;
            end else begin
               byte_val = 8'h00;
            end
         end
         ST_ROUND: begin
            work_in  = {rd, rc, {rb[1:0], rb[31:2]}, ra, t_sum};
            blk_in   = {blk_ff[479:0], w_mix[30:0], w_mix[31]};
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               round_in = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            priority if (fin_ff) state_in = ST_EMIT;
            else if (pad_ff) state_in = ST_PAD;
            else state_in = ST_ABSORB;
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[0];
               rsp_index_in = emit_ff;
               rsp_end_in   = (emit_ff == 3'(HASH_WORDS - 1));
               for (int i = 0; i < HASH_WORDS - 1; i++) begin
                  chain_in[i] = chain_ff[i+1];
               end
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'(HASH_WORDS - 1)) begin
                  // digest gone out, start the next message afresh
                  chain_in = H_INIT;
                  count_in = '0;
                  pad_in   = 1'b0;
                  mark_in  = 1'b0;
                  lenph_in = 1'b0;
                  fin_in   = 1'b0;
                  emit_in  = '0;
                  state_in = ST_ABSORB;
               end
            end
         end
         default: state_in = ST_ABSORB;
      endcase

      if (byte_wr) begin
         blk_in = {blk_ff[503:0], byte_val};
         pos_in = pos_ff + 6'd1;
         if (last_lane) begin
            work_in  = chain_ff;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ABSORB;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         count_ff     <= '0;
         chain_ff     <= H_INIT;
         round_ff     <= '0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         lenph_ff     <= 1'b0;
         fin_ff       <= 1'b0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         chain_ff     <= chain_in;
         round_ff     <= round_in;
         pad_ff       <= pad_in;
         mark_ff      <= mark_in;
         lenph_ff     <= lenph_in;
         fin_ff       <= fin_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      blk_ff       <= blk_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_index_ff;
   assign rsp_digest_end  = rsp_end_ff;

endmodule

FILE: src/sha1_message_digest.sv
// SHA-1 digest of a byte stream, one message byte per req transfer. The last item of a
// message (is_last, optionally with no_data for an empty tail) closes it with standard
// padding, and five rsp transfers follow carrying the digest, word 0 first, digest_end on
// word 4; the block is then ready for a new message. Items pass through a short queue
// (QUEUE_DEPTH entries) to a back end that shifts one byte per cycle into a 64-byte block
// while the queue holds an item and no compression runs, and runs the 80 rounds of the
// compression at one round per cycle, then folds the result into the chaining value.
// Closing a message writes one padding byte per cycle up to the block end, runs one or two
// compressions, and then sends the five digest words, each held while rsp_stall is high.
module sha1_message_digest #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_is_last,
   input  logic        req_no_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_end
);
   import sha1md_pkg::*;

   logic        q_full;
   logic        q_push;
   q_entry_type push_entry;
   logic        q_pop;
   logic        q_valid;
   q_entry_type pop_entry;

   sha1md_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .req_no_data   (req_no_data),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   sha1md_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   sha1md_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (pop_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_end  (rsp_digest_end)
   );

endmodule

FILE: src/sha1md_checker.sv
`include "sha1_message_digest_defines.svh"

module sha1md_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_digest_end
);

   // nothing comes out straight after reset
   `SHA1MD_ASSERT_ALWAYS(a_idle_after_reset, $past(reset), !rsp_valid, "rsp_valid high after reset")

   // a stalled digest word is held
   `SHA1MD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index) && $stable(rsp_digest_end), "stalled digest word changed")

   `SHA1MD_ASSERT_IMPL(a_index_range, rsp_valid, rsp_word_index <= 3'd4, "digest word index out of range")

   `SHA1MD_ASSERT_IMPL(a_end_flag, rsp_valid, rsp_digest_end == (rsp_word_index == 3'd4), "digest_end not on the fifth word")

   // digest words go out back to back and in order
   `SHA1MD_ASSERT_NEXT(a_word_order, rsp_valid && !rsp_stall && !rsp_digest_end, rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1), "digest words out of order")

endmodule

bind sha1_message_digest sha1md_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_digest_end  (rsp_digest_end)
);

FILE: tb/sha1_message_digest_tb.sv
module sha1_message_digest_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 280;
   localparam int IDLE_PCT     = 13;
   localparam int STRAY_PCT    = 5;
   localparam int DRAIN_CYCLES = 400;
   localparam int DEAD_LIMIT   = 4000;
   localparam int REPORT_MAX   = 10;

   localparam logic [31:0] IV0   = 32'h67452301;
   localparam logic [31:0] IV1   = 32'hEFCDAB89;
   localparam logic [31:0] IV2   = 32'h98BADCFE;
   localparam logic [31:0] IV3   = 32'h10325476;
   localparam logic [31:0] IV4   = 32'hC3D2E1F0;
   localparam logic [31:0] K_CH  = 32'h5A827999;
   localparam logic [31:0] K_PA  = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
   localparam logic [31:0] K_PB  = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_START   = 8'h80;
   localparam logic [5:0]  LEN_FIELD_AT = 6'd56;
   localparam int          DIGEST_WORDS = 5;

   typedef struct {
      logic [7:0] data;
      logic       is_last;
      logic       no_data;
      logic       hold;     // wait for every outstanding digest word before this transfer
   } msg_item_type;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        word_end;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_is_last = 1'b0;
   logic        req_no_data = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_digest_end;

   msg_item_type    items_to_send[$];
   digest_word_type digest_words_due[$];

   // digest state mirrored by the testbench
   logic [31:0] hash_state [DIGEST_WORDS];
   logic [31:0] block_buf [16];
   logic [63:0] length_bits;
   logic [5:0]  fill_pos;

   int stim_items = 0;
   int sent_items = 0;
   int errors = 0;
   int words_checked = 0;
   int messages_closed = 0;
   int msg_bytes = 0;
   int longest_msg = 0;
   int dead_cycles = 0;

   // both sides run without idling for a stretch of the run
   wire steady_window = (sent_items >= 100) && (sent_items < 170);

   sha1_message_digest DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_is_last     (req_is_last),
      .req_no_data     (req_no_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_digest_end  (rsp_digest_end)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void restart_digest();
      hash_state[0] = IV0;
      hash_state[1] = IV1;
      hash_state[2] = IV2;
      hash_state[3] = IV3;
      hash_state[4] = IV4;
      length_bits = 64'd0;
      fill_pos = 6'd0;
      msg_bytes = 0;
   endfunction

   function automatic void fold_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      w = block_buf;
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
         if (r >= 16)
            w[r % 16] = rol32(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16]
                              ^ w[r % 16], 1);
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_CH;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_PA;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = K_PB;
         end
         t = rol32(a, 5) + f + e + k + w[r % 16];
         e = d;
         d = c;
         c = rol32(b, 30);
         b = a;
         a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endfunction

   function automatic void append_byte(input logic [7:0] v);
      int sh;
      sh = 8 * (3 - int'(fill_pos[1:0]));
      if (fill_pos[1:0] == 2'd0)
         block_buf[fill_pos[5:2]] = 32'(v) << sh;
      else
         block_buf[fill_pos[5:2]][sh +: 8] = v;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0)
         fold_block();
   endfunction

   // one accepted item: absorb its byte, and on the last one pad and queue the digest
   function automatic void absorb_item(input logic [7:0] data, input logic is_last,
                                       input logic no_data);
      logic [63:0] len;
      digest_word_type dw;
      if (!no_data) begin
         length_bits += 64'd8;
         msg_bytes++;
         append_byte(data);
      end
      if (is_last) begin
         len = length_bits;
         append_byte(PAD_START);
         while (fill_pos != LEN_FIELD_AT)
            append_byte(8'h00);
         for (int i = 0; i < 8; i++)
            append_byte(len[8 * (7 - i) +: 8]);
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            dw.word = hash_state[i];
            dw.index = 3'(i);
            dw.word_end = (i == DIGEST_WORDS - 1);
            digest_words_due.push_back(dw);
         end
         if (msg_bytes > longest_msg)
            longest_msg = msg_bytes;
         messages_closed++;
         restart_digest();
      end
   endfunction

   function automatic void note_error(input string what);
      errors++;
      if (errors <= REPORT_MAX)
         $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   function automatic void push_item(input logic [7:0] data, input logic is_last,
                                     input logic no_data, input logic hold);
      msg_item_type it;
      it.data = data;
      it.is_last = is_last;
      it.no_data = no_data;
      it.hold = hold;
      items_to_send.push_back(it);
      // stray empty items are ignored by the block and do not count
      if (is_last || !no_data)
         stim_items++;
   endfunction

   function automatic void add_message(input int n_bytes, input bit end_empty,
                                       input bit hold_first);
      bit first;
      first = hold_first;
      for (int i = 0; i < n_bytes; i++) begin
         if ($urandom_range(99) < STRAY_PCT) begin
            push_item(8'($urandom_range(255)), 1'b0, 1'b1, first);
            first = 1'b0;
         end
         push_item(8'($urandom_range(255)), (i == n_bytes - 1) && !end_empty, 1'b0, first);
         first = 1'b0;
      end
      if (end_empty)
         push_item(8'($urandom_range(255)), 1'b1, 1'b1, first);
   endfunction

   // request side
   always @(posedge clock) begin : drive_req
      bit load;
      msg_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_item(req_data_byte, req_is_last, req_no_data);
            sent_items <= sent_items + 1;
         end
         if (!req_valid || !req_stall) begin
            load = (items_to_send.size() != 0)
                   && (steady_window || $urandom_range(99) >= IDLE_PCT);
            if (load && items_to_send[0].hold && digest_words_due.size() != 0)
               load = 1'b0;
            if (load) begin
               it = items_to_send.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= it.data;
               req_is_last   <= it.is_last;
               req_no_data   <= it.no_data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin : watch_rsp
      digest_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (digest_words_due.size() == 0) begin
               note_error($sformatf("unexpected digest word %h index %0d end %b",
                                    rsp_digest_word, rsp_word_index, rsp_digest_end));
            end else begin
               want = digest_words_due.pop_front();
               if (rsp_digest_word !== want.word || rsp_word_index !== want.index
                   || rsp_digest_end !== want.word_end)
                  note_error($sformatf("expected %h/%0d/%b got %h/%0d/%b",
                                       want.word, want.index, want.word_end,
                                       rsp_digest_word, rsp_word_index, rsp_digest_end));
            end
         end
         rsp_stall <= !steady_window && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dead_cycles <= 0;
      end else begin
         dead_cycles <= dead_cycles + 1;
         if (dead_cycles == DEAD_LIMIT) begin
            $display("no transfer for %0d cycles", DEAD_LIMIT);
            $display("sha1_message_digest_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      int block_sizes [6];
      int n;
      int msg_no;
      block_sizes = '{55, 56, 57, 63, 64, 65};
      restart_digest();

      // empty message, byte field ignored
      push_item(8'hA5, 1'b1, 1'b1, 1'b0);
      // one-byte messages, byte on the final item or before an empty tail, then a three-byte one
      push_item(8'h00, 1'b1, 1'b0, 1'b0);
      push_item(8'hFF, 1'b0, 1'b0, 1'b0);
      push_item(8'h00, 1'b1, 1'b1, 1'b0);
      push_item(8'h61, 1'b0, 1'b0, 1'b0);
      push_item(8'h62, 1'b0, 1'b0, 1'b0);
      push_item(8'h63, 1'b1, 1'b0, 1'b0);
      // stray empty items inside a message change nothing
      push_item(8'h80, 1'b0, 1'b0, 1'b0);
      push_item(8'h5A, 1'b0, 1'b1, 1'b0);
      push_item(8'h01, 1'b0, 1'b0, 1'b0);
      push_item(8'hC3, 1'b0, 1'b1, 1'b0);
      push_item(8'h7F, 1'b1, 1'b0, 1'b0);

      // mostly short messages, some right at the padding boundaries
      msg_no = 0;
      while (stim_items < ITEM_TARGET) begin
         if ($urandom_range(9) < 2)
            n = block_sizes[$urandom_range(5)];
         else
            n = $urandom_range(24);
         add_message(n, (n == 0) || ($urandom_range(1) == 1), (msg_no == 1) || (msg_no == 6));
         msg_no++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (items_to_send.size() != 0 || req_valid || digest_words_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (digest_words_due.size() != 0) begin
         errors += digest_words_due.size();
         $display("%0d digest words never arrived", digest_words_due.size());
      end
      $display("covered %0d messages over %0d transfers, longest %0d bytes",
               messages_closed, sent_items, longest_msg);
      $display("%0d digest words checked, %0d failures", words_checked, errors);
      if (errors == 0)
         $display("sha1_message_digest_tb: clean");
      else
         $display("sha1_message_digest_tb: errors");
      $finish;
   end

endmodule
